/* src/shadow_stack_call_edge_checker_macros.svh */
// Assertion helpers shared by the checker's modules.
// Every property is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef SHADOW_STACK_CALL_EDGE_CHECKER_MACROS_SVH
`define SHADOW_STACK_CALL_EDGE_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSCEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSCEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sscec_pkg.sv */
package sscec_pkg;

  localparam int ID_W    = 8;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 3;
  localparam int DEPTH_W = 7;
  localparam int NF_W    = 9;

  localparam logic [NF_W-1:0] NF_RESET = 9'd256;

  // Register file: one register, word aligned, selected by paddr[2].
  localparam int   CFG_ADDR_W            = 3;
  localparam int   CFG_DATA_W            = 32;
  localparam logic CFG_IDX_NUM_FUNCTIONS = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_VERIFY = 2'd2,
    ACT_EDGE   = 2'd3
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_POP_EMPTY    = 3'd1,
    ST_POP_MISMATCH = 3'd2,
    ST_OVERFLOW     = 3'd3,
    ST_UNKNOWN      = 3'd4,
    ST_NO_EDGE      = 3'd5
  } status_t;

  // Source of the offending ids in a result.
  typedef enum logic [1:0] {
    BAD_NONE  = 2'd0,
    BAD_INPUT = 2'd1,
    BAD_PAIR  = 2'd2
  } bad_sel_t;

  typedef struct packed {
    logic     capture;
    logic     push;
    logic     pop;
    logic     rd_top;
    logic     rd_next;
    logic     cap_callee;
    logic     pair_issue;
    logic     g_we;
    logic     clr_step;
    logic     res_we;
    status_t  res_code;
    bad_sel_t bad_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic full;
    logic empty;
    logic lt2;
    logic top_match;
    logic more;
    logic ids_known;
    logic s2_known;
    logic s2_edge;
    logic clr_last;
  } sts_t;

endpackage

/* src/sscec_datapath.sv */
`include "shadow_stack_call_edge_checker_macros.svh"

module sscec_datapath #(
  parameter int STACK_DEPTH   = 64,
  parameter int MAX_FUNCTIONS = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sscec_pkg::cmd_t                     cmd,
  output sscec_pkg::sts_t                     sts,
  input  logic [sscec_pkg::NF_W-1:0]          num_funcs,
  input  logic [sscec_pkg::ACT_W-1:0]         in_action,
  input  logic [sscec_pkg::ID_W-1:0]          in_func_id,
  input  logic [sscec_pkg::ID_W-1:0]          in_caller_id,
  input  logic                                in_edge_bit,
  output logic [sscec_pkg::STAT_W-1:0]        out_status,
  output logic [sscec_pkg::ID_W-1:0]          out_bad_caller,
  output logic [sscec_pkg::ID_W-1:0]          out_bad_callee,
  output logic [sscec_pkg::DEPTH_W-1:0]       out_depth_now
);

  localparam int SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int G_W   = $clog2(MAX_FUNCTIONS);
  localparam int MF_W  = $clog2(MAX_FUNCTIONS + 1);
  localparam int LIM_W = (MF_W > sscec_pkg::NF_W) ? MF_W : sscec_pkg::NF_W;
  localparam int IW    = sscec_pkg::ID_W;
  localparam int DW    = sscec_pkg::DEPTH_W;

  function automatic logic id_known(input logic [IW-1:0] id, input logic [LIM_W-1:0] limit);
    return LIM_W'(id) < limit;
  endfunction

  // Latched input word.
  sscec_pkg::act_t act_r;
  logic [IW-1:0]   fid_r;
  logic [IW-1:0]   cid_r;
  logic            ebit_r;

  logic [CNT_W-1:0] count_r;
  logic [SA_W-1:0]  walk_r;
  logic             more_r;
  logic [G_W-1:0]   clr_r;

  logic [IW-1:0]    st_mem [STACK_DEPTH];
  logic [IW-1:0]    st_q_r;
  logic [SA_W-1:0]  st_rd_addr;

  logic [MAX_FUNCTIONS-1:0] g_mem [MAX_FUNCTIONS];
  logic                     g_q_r;

  logic [IW-1:0] callee_r;
  logic [IW-1:0] s2_caller_r;
  logic [IW-1:0] s2_callee_r;
  logic          s2_known_r;

  sscec_pkg::status_t res_status_r;
  logic [IW-1:0]      res_caller_r;
  logic [IW-1:0]      res_callee_r;

  logic [sscec_pkg::STAT_W-1:0] out_status_r;
  logic [IW-1:0]                out_caller_r;
  logic [IW-1:0]                out_callee_r;
  logic [DW-1:0]                out_depth_r;

  logic [LIM_W-1:0] lim;
  logic full;
  logic known_cid;
  logic known_fid;

  // Ids below this bound are known; the register may ask for more functions than
  // the matrix holds, so it is clamped to the matrix size.
  assign lim = (LIM_W'(num_funcs) < LIM_W'(MAX_FUNCTIONS)) ? LIM_W'(num_funcs)
                                                           : LIM_W'(MAX_FUNCTIONS);

  assign full       = (count_r == CNT_W'(STACK_DEPTH));
  assign known_cid  = id_known(cid_r, lim);
  assign known_fid  = id_known(fid_r, lim);
  assign st_rd_addr = cmd.rd_top ? SA_W'(count_r - CNT_W'(1)) : walk_r;

  always_comb begin
    sts.act       = act_r;
    sts.full      = full;
    sts.empty     = (count_r == '0);
    sts.lt2       = (count_r < CNT_W'(2));
    sts.top_match = (st_q_r == fid_r);
    sts.more      = more_r;
    sts.ids_known = known_cid && known_fid;
    sts.s2_known  = s2_known_r;
    sts.s2_edge   = g_q_r;
    sts.clr_last  = (clr_r == G_W'(MAX_FUNCTIONS - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= sscec_pkg::act_t'(in_action);
      fid_r  <= in_func_id;
      cid_r  <= in_caller_id;
      ebit_r <= in_edge_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      walk_r  <= '0;
      more_r  <= 1'b0;
      clr_r   <= '0;
    end else begin
      if (cmd.push) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.pop) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.rd_top) begin
        walk_r <= SA_W'(count_r - CNT_W'(2));
        more_r <= 1'b1;
      end else if (cmd.rd_next) begin
        if (walk_r == '0) begin
          more_r <= 1'b0;
        end else begin
          walk_r <= walk_r - SA_W'(1);
        end
      end
      if (cmd.clr_step) begin
        clr_r <= clr_r + G_W'(1);
      end
    end
  end

  // Shadow stack storage.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      st_mem[SA_W'(count_r)] <= fid_r;
    end
    if (cmd.rd_top || cmd.rd_next) begin
      st_q_r <= st_mem[st_rd_addr];
    end
  end

  // Call-graph matrix, one row per caller.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      g_mem[clr_r] <= '0;
    end else if (cmd.g_we) begin
      g_mem[G_W'(cid_r)][G_W'(fid_r)] <= ebit_r;
    end
    if (cmd.pair_issue) begin
      g_q_r <= g_mem[G_W'(st_q_r)][G_W'(callee_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_callee || cmd.pair_issue) begin
      callee_r <= st_q_r;
    end
    if (cmd.pair_issue) begin
      s2_caller_r <= st_q_r;
      s2_callee_r <= callee_r;
      s2_known_r  <= id_known(st_q_r, lim) && id_known(callee_r, lim);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      res_status_r <= cmd.res_code;
      case (cmd.bad_sel)
        sscec_pkg::BAD_INPUT: begin
          res_caller_r <= cid_r;
          res_callee_r <= fid_r;
        end
        sscec_pkg::BAD_PAIR: begin
          res_caller_r <= s2_caller_r;
          res_callee_r <= s2_callee_r;
        end
        default: begin
          res_caller_r <= '0;
          res_callee_r <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_caller_r <= res_caller_r;
      out_callee_r <= res_callee_r;
      out_depth_r  <= DW'(count_r);
    end
  end

  assign out_status     = out_status_r;
  assign out_bad_caller = out_caller_r;
  assign out_bad_callee = out_callee_r;
  assign out_depth_now  = out_depth_r;

  `SSCEC_ASSERT_IMP(a_push_not_full, cmd.push, !full, "push issued on a full stack")
  `SSCEC_ASSERT_IMP(a_pop_not_empty, cmd.pop, count_r != '0, "pop issued on an empty stack")
  `SSCEC_ASSERT_IMP(a_edge_ids_known, cmd.g_we, known_cid && known_fid, "edge write with unknown id")

endmodule

/* src/sscec_ctrl.sv */
`include "shadow_stack_call_edge_checker_macros.svh"

module sscec_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  sscec_pkg::sts_t sts,
  output sscec_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_POP_CHK,
    S_V_HEAD,
    S_V_RUN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   st_v_r, st_v_nxt;
  logic   s2_v_r, s2_v_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    st_v_nxt      = 1'b0;
    s2_v_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.act)
          sscec_pkg::ACT_PUSH: begin
            cmd.res_we = 1'b1;
            if (sts.full) begin
              cmd.res_code = sscec_pkg::ST_OVERFLOW;
            end else begin
              cmd.push     = 1'b1;
              cmd.res_code = sscec_pkg::ST_OK;
            end
            state_nxt = S_FINISH;
          end
          sscec_pkg::ACT_POP: begin
            if (sts.empty) begin
              cmd.res_we   = 1'b1;
              cmd.res_code = sscec_pkg::ST_POP_EMPTY;
              state_nxt    = S_FINISH;
            end else begin
              cmd.rd_top = 1'b1;
              state_nxt  = S_POP_CHK;
            end
          end
          sscec_pkg::ACT_VERIFY: begin
            if (sts.lt2) begin
              cmd.res_we   = 1'b1;
              cmd.res_code = sscec_pkg::ST_OK;
              state_nxt    = S_FINISH;
            end else begin
              cmd.rd_top = 1'b1;
              state_nxt  = S_V_HEAD;
            end
          end
          sscec_pkg::ACT_EDGE: begin
            cmd.res_we = 1'b1;
            if (sts.ids_known) begin
              cmd.g_we     = 1'b1;
              cmd.res_code = sscec_pkg::ST_OK;
            end else begin
              cmd.res_code = sscec_pkg::ST_UNKNOWN;
              cmd.bad_sel  = sscec_pkg::BAD_INPUT;
            end
            state_nxt = S_FINISH;
          end
          default: begin
            cmd.res_we   = 1'b1;
            cmd.res_code = sscec_pkg::ST_OK;
            state_nxt    = S_FINISH;
          end
        endcase
      end
      S_POP_CHK: begin
        cmd.res_we = 1'b1;
        if (sts.top_match) begin
          cmd.pop      = 1'b1;
          cmd.res_code = sscec_pkg::ST_OK;
        end else begin
          cmd.res_code = sscec_pkg::ST_POP_MISMATCH;
        end
        state_nxt = S_FINISH;
      end
      S_V_HEAD: begin
        // The top entry is the first callee; fetch the entry below it.
        cmd.cap_callee = 1'b1;
        cmd.rd_next    = 1'b1;
        st_v_nxt       = 1'b1;
        state_nxt      = S_V_RUN;
      end
      S_V_RUN: begin
        if (s2_v_r && (!sts.s2_known || !sts.s2_edge)) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = sts.s2_known ? sscec_pkg::ST_NO_EDGE : sscec_pkg::ST_UNKNOWN;
          cmd.bad_sel  = sscec_pkg::BAD_PAIR;
          state_nxt    = S_FINISH;
        end else begin
          if (st_v_r) begin
            cmd.pair_issue = 1'b1;
            s2_v_nxt       = 1'b1;
          end
          if (sts.more) begin
            cmd.rd_next = 1'b1;
            st_v_nxt    = 1'b1;
          end
          if (!st_v_r && !s2_v_r) begin
            cmd.res_we   = 1'b1;
            cmd.res_code = sscec_pkg::ST_OK;
            state_nxt    = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      st_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_v_r      <= st_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SSCEC_ASSERT_IMP(a_load_when_free, cmd.out_load, !out_valid_r || !out_stall, "result overwrites a waiting word")
  `SSCEC_ASSERT_IMP(a_s2_only_in_walk, s2_v_r, state_r == S_V_RUN, "pair check outside the stack walk")
  `SSCEC_ASSERT_NEXT(a_walk_ends, (state_r == S_V_RUN) && !st_v_r && !s2_v_r, state_r == S_FINISH, "empty walk did not finish")

endmodule

/* src/shadow_stack_call_edge_checker.sv */
// Channel   Direction  Handshake           Word
// input     in         in_valid/in_stall   action, func_id, caller_id, edge_bit
// result    out        out_valid/out_stall status, bad_caller, bad_callee, depth_now
// config    in         APB psel/penable    num_functions at byte address 0
//
// Push and edge write go from acceptance through decode to finish, which loads the
// result; pop adds a check of the top entry (not on an empty stack). Verify with fewer
// than two entries finishes from decode; else the walk is set by one stack read and
// one call-graph lookup per entry, pipelined so that one pair retires a cycle.
// After reset a clearing pass writes MAX_FUNCTIONS rows of the call graph, one row a
// cycle, and no word is accepted until it completes.
// A waiting result only holds back the finish of the next word, never its acceptance.

module shadow_stack_call_edge_checker #(
  parameter int STACK_DEPTH   = 64,
  parameter int MAX_FUNCTIONS = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input words.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [sscec_pkg::ACT_W-1:0]           in_action,
  input  logic [sscec_pkg::ID_W-1:0]            in_func_id,
  input  logic [sscec_pkg::ID_W-1:0]            in_caller_id,
  input  logic                                  in_edge_bit,
  // Result words.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [sscec_pkg::STAT_W-1:0]          out_status,
  output logic [sscec_pkg::ID_W-1:0]            out_bad_caller,
  output logic [sscec_pkg::ID_W-1:0]            out_bad_callee,
  output logic [sscec_pkg::DEPTH_W-1:0]         out_depth_now,
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sscec_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [sscec_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [sscec_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                  pready
);

  localparam int NW    = sscec_pkg::NF_W;
  localparam int CDW   = sscec_pkg::CFG_DATA_W;

  logic [NW-1:0]    nf_r;
  logic             cfg_sel;

  sscec_pkg::cmd_t cmd;
  sscec_pkg::sts_t sts;

  // The register is selected by its word index; byte lanes are not decoded.
  assign cfg_sel = (paddr[2] == sscec_pkg::CFG_IDX_NUM_FUNCTIONS);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? CDW'(nf_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r <= sscec_pkg::NF_RESET;
    end else if (psel && penable && pwrite && cfg_sel) begin
      nf_r <= pwdata[NW-1:0];
    end
  end

  sscec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sscec_datapath #(
    .STACK_DEPTH   (STACK_DEPTH),
    .MAX_FUNCTIONS (MAX_FUNCTIONS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .num_funcs      (nf_r),
    .in_action      (in_action),
    .in_func_id     (in_func_id),
    .in_caller_id   (in_caller_id),
    .in_edge_bit    (in_edge_bit),
    .out_status     (out_status),
    .out_bad_caller (out_bad_caller),
    .out_bad_callee (out_bad_callee),
    .out_depth_now  (out_depth_now)
  );

endmodule
